>>> hdl/ccm_pkg.sv
// ccm_pkg: shared widths, codes and types for the coldest-core task migrator
// used by every module of the block but ccm_checker; depends on nothing
package ccm_pkg;

  localparam int DEF_MESH_ROWS = 8;
  localparam int DEF_MESH_COLS = 8;

  localparam int FUNC_W  = 2;
  localparam int POS_W   = 3;
  localparam int TEMP_W  = 12;
  localparam int TASK_W  = 6;
  localparam int HOP_W   = 4;
  localparam int TOTAL_W = 32;

  localparam int NUM_TASKS = 2 ** TASK_W;
  localparam int MAX_HOT   = 64;
  localparam int HOT_IDX_W = $clog2(MAX_HOT);
  localparam int HOT_CNT_W = HOT_IDX_W + 1;

  localparam int CMDQ_DEPTH = 2;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [TEMP_W-1:0] THRESH_RESET = 12'd1280;

  // register index taken from the word address bit
  localparam logic REG_HOT_THRESHOLD = 1'b0;

  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PLACE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CHECK  = 2'd2;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_PLACE  = 2'd1,
    OP_CHECK  = 2'd2
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e           op;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [TEMP_W-1:0] temp;
    logic [TASK_W-1:0] task_id;
  } cmd_t;

  typedef struct packed {
    logic [TASK_W-1:0]  task_moved_id;
    logic [POS_W-1:0]   from_row;
    logic [POS_W-1:0]   from_col;
    logic [POS_W-1:0]   to_row;
    logic [POS_W-1:0]   to_col;
    logic [HOP_W-1:0]   hop_distance;
    logic               moved;
    logic               none_hot;
    logic [TOTAL_W-1:0] total_hops;
    logic               last;
  } res_t;

endpackage

>>> hdl/ccm_front.sv
// ccm_front: input side of the migrator, decodes and filters items into commands
// depends on ccm_pkg
module ccm_front import ccm_pkg::*; #(
  parameter int MESH_ROWS = DEF_MESH_ROWS,
  parameter int MESH_COLS = DEF_MESH_COLS
) (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [POS_W-1:0]  core_row_i,
  input  logic [POS_W-1:0]  core_col_i,
  input  logic [TEMP_W-1:0] temperature_i,
  input  logic [TASK_W-1:0] task_id_i,
  input  logic              q_full_i,
  output logic              push_o,
  output cmd_t              cmd_o
);

  logic in_mesh;
  logic keep;

  assign in_mesh = ({29'd0, core_row_i} < 32'(MESH_ROWS)) &&
                   ({29'd0, core_col_i} < 32'(MESH_COLS));

  always_comb begin
    cmd_o.row     = core_row_i;
    cmd_o.col     = core_col_i;
    cmd_o.temp    = temperature_i;
    cmd_o.task_id = task_id_i;
    unique case (func_i)
      FUNC_SAMPLE: begin
        cmd_o.op = OP_SAMPLE;
        keep     = in_mesh;
      end
      FUNC_PLACE: begin
        cmd_o.op = OP_PLACE;
        keep     = in_mesh;
      end
      FUNC_CHECK: begin
        cmd_o.op = OP_CHECK;
        keep     = 1'b1;
      end
      default: begin
        // unknown codes are dropped here; off-mesh samples and placements fail in_mesh
        cmd_o.op = OP_SAMPLE;
        keep     = 1'b0;
      end
    endcase
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && keep;

endmodule

>>> hdl/ccm_cmd_fifo.sv
// ccm_cmd_fifo: short command queue between front and back of the migrator
// depends on ccm_pkg
module ccm_cmd_fifo import ccm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output cmd_t cmd_o
);

  localparam int PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  cmd_t             mem_q [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(CMDQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= cmd_i;
  end

endmodule

>>> hdl/ccm_back.sv
// ccm_back: executes commands against the core tables and runs thermal checks
// depends on ccm_pkg; holds the owner, temperature, placement and hot-list memories
module ccm_back import ccm_pkg::*; #(
  parameter int MESH_ROWS = DEF_MESH_ROWS,
  parameter int MESH_COLS = DEF_MESH_COLS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  cmd_t              cmd_i,
  output logic              pop_o,
  input  logic [TEMP_W-1:0] thr_i,
  input  logic              out_stall_i,
  output logic              out_vld_o,
  output res_t              res_o
);

  localparam int ROW_W  = $clog2(MESH_ROWS);
  localparam int COL_W  = $clog2(MESH_COLS);
  localparam int CORE_W = ROW_W + COL_W;
  localparam int NCORE  = 2 ** CORE_W;
  localparam int DIST_W = ((ROW_W > COL_W) ? ROW_W : COL_W) + 1;
  localparam int SUM_W  = TOTAL_W + 1;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MESH_ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MESH_COLS - 1);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_PL_OWN   = 9'b000000010,
    ST_PL_WR    = 9'b000000100,
    ST_COLLECT  = 9'b000001000,
    ST_HOT_CHK  = 9'b000010000,
    ST_HOT_RD   = 9'b000100000,
    ST_OWN_RD   = 9'b001000000,
    ST_MIG_SCAN = 9'b010000000,
    ST_EMIT     = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // control
  logic [ROW_W-1:0]     scan_row_q, scan_row_d;
  logic [COL_W-1:0]     scan_col_q, scan_col_d;
  logic                 issue_done_q, issue_done_d;
  logic                 p_vld_q, p_vld_d;
  logic                 p_last_q, p_last_d;
  logic [HOT_CNT_W-1:0] hot_n_q, hot_n_d;
  logic [HOT_IDX_W-1:0] hot_i_q, hot_i_d;
  logic                 nh_q, nh_d;
  logic [TOTAL_W-1:0]   hop_total_q, hop_total_d;
  logic                 out_vld_q, out_vld_d;

  // data
  cmd_t                 cmd_q, cmd_d;
  logic [ROW_W-1:0]     p_row_q, p_row_d;
  logic [COL_W-1:0]     p_col_q, p_col_d;
  logic [CORE_W-1:0]    from_q, from_d;
  logic [CORE_W-1:0]    old_q, old_d;
  logic [CORE_W-1:0]    best_q, best_d;
  logic [TEMP_W-1:0]    best_temp_q, best_temp_d;
  logic                 found_q, found_d;
  res_t                 res_q, res_d;

  // memories and their valid bits
  logic [TEMP_W-1:0] temp_mem  [NCORE];
  logic [TASK_W-1:0] owner_mem [NCORE];
  logic [CORE_W-1:0] place_mem [NUM_TASKS];
  logic [CORE_W-1:0] hot_mem   [MAX_HOT];
  logic [NCORE-1:0]     temp_vld_q, owner_vld_q, owner_vld_d;
  logic [NUM_TASKS-1:0] place_vld_q;

  // memory access controls
  logic                 temp_we, temp_re;
  logic [CORE_W-1:0]    temp_wa;
  logic [TEMP_W-1:0]    temp_wd;
  logic                 ov_re, ov_clr, ov_set;
  logic [CORE_W-1:0]    ov_ra, ov_clr_a, ov_set_a;
  logic                 own_we, own_re;
  logic [CORE_W-1:0]    own_wa, own_ra;
  logic [TASK_W-1:0]    own_wd;
  logic                 pl_we, pl_re;
  logic [TASK_W-1:0]    pl_wa, pl_ra;
  logic [CORE_W-1:0]    pl_wd;
  logic                 hot_we, hot_re;
  logic [HOT_IDX_W-1:0] hot_wa, hot_ra;
  logic [CORE_W-1:0]    hot_wd;

  // registered read data
  logic [TEMP_W-1:0] temp_rd_q;
  logic              tv_rd_q, ov_rd_q, pv_rd_q;
  logic [TASK_W-1:0] owner_rd_q;
  logic [CORE_W-1:0] place_rd_q, hot_rd_q;

  // helpers
  logic [CORE_W-1:0] scan_addr, cmd_core, pl_old;
  logic              scan_last, p_fin, slot_free, last_hit;
  logic [TEMP_W-1:0] temp_eff;
  logic [ROW_W-1:0]  fr_row, bs_row, d_row;
  logic [COL_W-1:0]  fr_col, bs_col, d_col;
  logic [DIST_W-1:0] hop;
  logic [SUM_W-1:0]  hop_sum;
  logic [TOTAL_W-1:0] hop_sat;

  assign scan_addr = {scan_row_q, scan_col_q};
  assign scan_last = (scan_row_q == ROW_LAST) && (scan_col_q == COL_LAST);
  assign p_fin     = p_vld_q && p_last_q;
  assign temp_eff  = tv_rd_q ? temp_rd_q : '0;
  assign cmd_core  = {ROW_W'(cmd_q.row), COL_W'(cmd_q.col)};
  assign pl_old    = pv_rd_q ? place_rd_q : '0;
  assign slot_free = !out_vld_q || !out_stall_i;
  assign last_hit  = (HOT_CNT_W'(hot_i_q) + HOT_CNT_W'(1)) == hot_n_q;

  assign fr_row  = from_q[CORE_W-1:COL_W];
  assign fr_col  = from_q[COL_W-1:0];
  assign bs_row  = best_q[CORE_W-1:COL_W];
  assign bs_col  = best_q[COL_W-1:0];
  assign d_row   = (fr_row > bs_row) ? fr_row - bs_row : bs_row - fr_row;
  assign d_col   = (fr_col > bs_col) ? fr_col - bs_col : bs_col - fr_col;
  assign hop     = DIST_W'(d_row) + DIST_W'(d_col);
  assign hop_sum = {1'b0, hop_total_q} + SUM_W'(hop);
  assign hop_sat = hop_sum[TOTAL_W] ? '1 : hop_sum[TOTAL_W-1:0];

  always_comb begin
    state_d      = state_q;
    scan_row_d   = scan_row_q;
    scan_col_d   = scan_col_q;
    issue_done_d = issue_done_q;
    p_vld_d      = 1'b0;
    p_last_d     = 1'b0;
    p_row_d      = scan_row_q;
    p_col_d      = scan_col_q;
    hot_n_d      = hot_n_q;
    hot_i_d      = hot_i_q;
    nh_d         = nh_q;
    hop_total_d  = hop_total_q;
    out_vld_d    = out_vld_q && out_stall_i;
    cmd_d        = cmd_q;
    from_d       = from_q;
    old_d        = old_q;
    best_d       = best_q;
    best_temp_d  = best_temp_q;
    found_d      = found_q;
    res_d        = res_q;
    pop_o        = 1'b0;

    temp_we  = 1'b0;
    temp_wa  = {ROW_W'(cmd_i.row), COL_W'(cmd_i.col)};
    temp_wd  = cmd_i.temp;
    temp_re  = 1'b0;
    ov_re    = 1'b0;
    ov_ra    = scan_addr;
    ov_clr   = 1'b0;
    ov_clr_a = old_q;
    ov_set   = 1'b0;
    ov_set_a = cmd_core;
    own_we   = 1'b0;
    own_wa   = cmd_core;
    own_wd   = cmd_q.task_id;
    own_re   = 1'b0;
    own_ra   = pl_old;
    pl_we    = 1'b0;
    pl_wa    = cmd_q.task_id;
    pl_wd    = cmd_core;
    pl_re    = 1'b0;
    pl_ra    = cmd_i.task_id;
    hot_we   = 1'b0;
    hot_wa   = hot_n_q[HOT_IDX_W-1:0];
    hot_wd   = {p_row_q, p_col_q};
    hot_re   = 1'b0;
    hot_ra   = hot_i_q;

    // shared row-major scan issue for collect and coldest search
    if (((state_q == ST_COLLECT) || (state_q == ST_MIG_SCAN)) && !issue_done_q) begin
      temp_re  = 1'b1;
      ov_re    = 1'b1;
      p_vld_d  = 1'b1;
      p_last_d = scan_last;
      if (scan_last) issue_done_d = 1'b1;
      if (scan_col_q == COL_LAST) begin
        scan_col_d = '0;
        scan_row_d = scan_row_q + 1'b1;
      end else begin
        scan_col_d = scan_col_q + 1'b1;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          unique case (cmd_i.op)
            OP_SAMPLE: begin
              temp_we = 1'b1;
            end
            OP_PLACE: begin
              pl_re   = 1'b1;
              state_d = ST_PL_OWN;
            end
            OP_CHECK: begin
              scan_row_d   = '0;
              scan_col_d   = '0;
              issue_done_d = 1'b0;
              hot_n_d      = '0;
              state_d      = ST_COLLECT;
            end
            default: ;
          endcase
        end
      end
      ST_PL_OWN: begin
        own_re  = 1'b1;
        ov_re   = 1'b1;
        ov_ra   = pl_old;
        old_d   = pl_old;
        state_d = ST_PL_WR;
      end
      ST_PL_WR: begin
        // free the task's previous core only if it still holds it
        if ((old_q != cmd_core) && ov_rd_q && (owner_rd_q == cmd_q.task_id)) begin
          ov_clr = 1'b1;
        end
        ov_set  = 1'b1;
        own_we  = 1'b1;
        pl_we   = 1'b1;
        state_d = ST_IDLE;
      end
      ST_COLLECT: begin
        if (p_vld_q && ov_rd_q && (temp_eff > thr_i) &&
            (hot_n_q != HOT_CNT_W'(MAX_HOT))) begin
          hot_we  = 1'b1;
          hot_n_d = hot_n_q + 1'b1;
        end
        if (p_fin) state_d = ST_HOT_CHK;
      end
      ST_HOT_CHK: begin
        hot_i_d = '0;
        if (hot_n_q == '0) begin
          nh_d    = 1'b1;
          state_d = ST_EMIT;
        end else begin
          nh_d    = 1'b0;
          state_d = ST_HOT_RD;
        end
      end
      ST_HOT_RD: begin
        hot_re  = 1'b1;
        state_d = ST_OWN_RD;
      end
      ST_OWN_RD: begin
        own_re       = 1'b1;
        own_ra       = hot_rd_q;
        from_d       = hot_rd_q;
        ov_clr       = 1'b1;
        ov_clr_a     = hot_rd_q;
        scan_row_d   = '0;
        scan_col_d   = '0;
        issue_done_d = 1'b0;
        best_temp_d  = thr_i;
        best_d       = '0;
        found_d      = 1'b0;
        state_d      = ST_MIG_SCAN;
      end
      ST_MIG_SCAN: begin
        // strict less-than keeps the first core on a tie
        if (p_vld_q && !ov_rd_q && (temp_eff < best_temp_q)) begin
          best_temp_d = temp_eff;
          best_d      = {p_row_q, p_col_q};
          found_d     = 1'b1;
        end
        if (p_fin) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_vld_d = 1'b1;
          if (nh_q) begin
            res_d            = '0;
            res_d.none_hot   = 1'b1;
            res_d.last       = 1'b1;
            res_d.total_hops = hop_total_q;
            state_d          = ST_IDLE;
          end else begin
            res_d.task_moved_id = owner_rd_q;
            res_d.from_row      = POS_W'(fr_row);
            res_d.from_col      = POS_W'(fr_col);
            res_d.none_hot      = 1'b0;
            res_d.last          = last_hit;
            if (found_q) begin
              res_d.to_row       = POS_W'(bs_row);
              res_d.to_col       = POS_W'(bs_col);
              res_d.hop_distance = HOP_W'(hop);
              res_d.moved        = 1'b1;
              res_d.total_hops   = hop_sat;
              hop_total_d        = hop_sat;
              ov_set             = 1'b1;
              ov_set_a           = best_q;
              own_we             = 1'b1;
              own_wa             = best_q;
              own_wd             = owner_rd_q;
              pl_we              = 1'b1;
              pl_wa              = owner_rd_q;
              pl_wd              = best_q;
            end else begin
              // no cold free core: the task goes back to its own core
              res_d.to_row       = POS_W'(fr_row);
              res_d.to_col       = POS_W'(fr_col);
              res_d.hop_distance = '0;
              res_d.moved        = 1'b0;
              res_d.total_hops   = hop_total_q;
              ov_set             = 1'b1;
              ov_set_a           = from_q;
            end
            if (last_hit) begin
              state_d = ST_IDLE;
            end else begin
              hot_i_d = hot_i_q + 1'b1;
              state_d = ST_HOT_RD;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      scan_row_q   <= '0;
      scan_col_q   <= '0;
      issue_done_q <= 1'b1;
      p_vld_q      <= 1'b0;
      p_last_q     <= 1'b0;
      hot_n_q      <= '0;
      hot_i_q      <= '0;
      nh_q         <= 1'b0;
      hop_total_q  <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      scan_row_q   <= scan_row_d;
      scan_col_q   <= scan_col_d;
      issue_done_q <= issue_done_d;
      p_vld_q      <= p_vld_d;
      p_last_q     <= p_last_d;
      hot_n_q      <= hot_n_d;
      hot_i_q      <= hot_i_d;
      nh_q         <= nh_d;
      hop_total_q  <= hop_total_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    p_row_q     <= p_row_d;
    p_col_q     <= p_col_d;
    from_q      <= from_d;
    old_q       <= old_d;
    best_q      <= best_d;
    best_temp_q <= best_temp_d;
    found_q     <= found_d;
    res_q       <= res_d;
  end

  // a placement may free one core and take another in the same cycle
  always_comb begin
    owner_vld_d = owner_vld_q;
    if (ov_clr) owner_vld_d[ov_clr_a] = 1'b0;
    if (ov_set) owner_vld_d[ov_set_a] = 1'b1;
  end

  // valid bits stand for the reset values of the tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_vld_q  <= '0;
      owner_vld_q <= '0;
      place_vld_q <= '0;
    end else begin
      if (temp_we) temp_vld_q[temp_wa]  <= 1'b1;
      if (pl_we)   place_vld_q[pl_wa]   <= 1'b1;
      owner_vld_q <= owner_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (temp_we) temp_mem[temp_wa] <= temp_wd;
    if (temp_re) begin
      temp_rd_q <= temp_mem[scan_addr];
      tv_rd_q   <= temp_vld_q[scan_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ov_re) ov_rd_q <= owner_vld_q[ov_ra];
  end

  always_ff @(posedge clk_i) begin
    if (own_we) owner_mem[own_wa] <= own_wd;
    if (own_re) owner_rd_q <= owner_mem[own_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pl_we) place_mem[pl_wa] <= pl_wd;
    if (pl_re) begin
      place_rd_q <= place_mem[pl_ra];
      pv_rd_q    <= place_vld_q[pl_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hot_we) hot_mem[hot_wa] <= hot_wd;
    if (hot_re) hot_rd_q <= hot_mem[hot_ra];
  end

  assign out_vld_o = out_vld_q;
  assign res_o     = res_q;

endmodule

>>> hdl/coldest_core_task_migrator.sv
// coldest_core_task_migrator: top level with the threshold register and APB port
// depends on ccm_pkg, ccm_front, ccm_cmd_fifo and ccm_back
//
// Input items (func, core_row, core_col, temperature, task_id) are taken on
// in_valid_i while in_stall_o is low. Samples and placements on cores inside
// the mesh update the tables; func 3 and off-mesh samples and placements are dropped. A thermal
// check returns one result item per hot task, or one none_hot item, on
// out_valid_o; the receiver holds it with out_stall_i and the item stays put.
// A two-entry command queue lets items keep arriving while results wait.
// Back end steps, with the N = MESH_ROWS * MESH_COLS cores scanned one a cycle:
//   a sample writes the temperature table, a placement does two dependent table
//   reads then the write, and a check runs the hot-core collect scan, then gives
//   a none_hot item or runs a coldest-core search scan for each hot task; the
//   receiver can stall each result item.
// Reset empties all cores, zeroes temperatures, placements and the hop total,
// and loads hot_threshold with 1280; no clearing pass is needed.
// The APB port (pready always high) reads and writes hot_threshold at 0.
module coldest_core_task_migrator import ccm_pkg::*; #(
  parameter int MESH_ROWS = DEF_MESH_ROWS,
  parameter int MESH_COLS = DEF_MESH_COLS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [POS_W-1:0]      core_row_i,
  input  logic [POS_W-1:0]      core_col_i,
  input  logic [TEMP_W-1:0]     temperature_i,
  input  logic [TASK_W-1:0]     task_id_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [TASK_W-1:0]     task_moved_id_o,
  output logic [POS_W-1:0]      from_row_o,
  output logic [POS_W-1:0]      from_col_o,
  output logic [POS_W-1:0]      to_row_o,
  output logic [POS_W-1:0]      to_col_o,
  output logic [HOP_W-1:0]      hop_distance_o,
  output logic                  moved_o,
  output logic                  none_hot_o,
  output logic [TOTAL_W-1:0]    total_hops_o,
  output logic                  last_o
);

  logic [TEMP_W-1:0] thr_q;
  logic              cfg_wr;
  logic              q_full, q_empty, q_push, q_pop;
  cmd_t              push_cmd, head_cmd;
  res_t              res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[APB_ADDR_W-1] == REG_HOT_THRESHOLD);
  assign prdata = (paddr[APB_ADDR_W-1] == REG_HOT_THRESHOLD) ?
                  APB_DATA_W'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RESET;
    end else if (cfg_wr) begin
      thr_q <= pwdata[TEMP_W-1:0];
    end
  end

  ccm_front #(
    .MESH_ROWS (MESH_ROWS),
    .MESH_COLS (MESH_COLS)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .core_row_i    (core_row_i),
    .core_col_i    (core_col_i),
    .temperature_i (temperature_i),
    .task_id_i     (task_id_i),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .cmd_o         (push_cmd)
  );

  ccm_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .cmd_o   (head_cmd)
  );

  ccm_back #(
    .MESH_ROWS (MESH_ROWS),
    .MESH_COLS (MESH_COLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .cmd_i       (head_cmd),
    .pop_o       (q_pop),
    .thr_i       (thr_q),
    .out_stall_i (out_stall_i),
    .out_vld_o   (out_valid_o),
    .res_o       (res)
  );

  assign task_moved_id_o = res.task_moved_id;
  assign from_row_o      = res.from_row;
  assign from_col_o      = res.from_col;
  assign to_row_o        = res.to_row;
  assign to_col_o        = res.to_col;
  assign hop_distance_o  = res.hop_distance;
  assign moved_o         = res.moved;
  assign none_hot_o      = res.none_hot;
  assign total_hops_o    = res.total_hops;
  assign last_o          = res.last;

endmodule

>>> hdl/ccm_checker.sv
// ccm_checker: port-level assertions for the coldest-core task migrator
// bound to coldest_core_task_migrator; depends on its port list only
module ccm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [5:0]  task_moved_id_o,
  input logic [2:0]  from_row_o,
  input logic [2:0]  from_col_o,
  input logic [2:0]  to_row_o,
  input logic [2:0]  to_col_o,
  input logic [3:0]  hop_distance_o,
  input logic        moved_o,
  input logic        none_hot_o,
  input logic [31:0] total_hops_o,
  input logic        last_o
);

  // a stalled result item keeps its place and its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable({task_moved_id_o, from_row_o, from_col_o, to_row_o, to_col_o,
               hop_distance_o, moved_o, none_hot_o, total_hops_o, last_o}))
    else $error("stalled result item changed");

  // the no-hot-core answer is a single, empty, final item
  a_none_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && none_hot_o |-> last_o && !moved_o && hop_distance_o == 4'd0 &&
      task_moved_id_o == 6'd0)
    else $error("none_hot item is not an empty final item");

  // a task that found no cold core stays on its own core
  a_stay_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !moved_o |-> hop_distance_o == 4'd0 && to_row_o == from_row_o &&
      to_col_o == from_col_o)
    else $error("unmoved task reports a different target");

endmodule

bind coldest_core_task_migrator ccm_checker u_ccm_checker (.*);
